/* sv/bpam_pkg.sv */
// ----------------------------------------------------------------------------
// bpam_pkg - battery pack alarm monitor shared definitions
// Word layouts, limit registers, command codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bpam_pkg;

  localparam int VOLT_W     = 16;
  localparam int CODE_W     = 12;
  localparam int CUR_W      = 14;
  localparam int CMD_W      = 8;
  localparam int FLAGS4_W   = 4;
  localparam int CHARGE_W   = 8;
  localparam int FAULT_W    = 3;
  localparam int WARN_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CMD_W-1:0]  CMD_OPEN      = 8'h00;
  localparam logic [CMD_W-1:0]  CMD_PRECHARGE = 8'h08;
  localparam logic [CMD_W-1:0]  CMD_MAIN      = 8'h0F;
  localparam logic [VOLT_W-1:0] LINK_TIMEOUT  = 16'd1000;

  // total / 6 == (total * DIV6_MUL) >> DIV6_SHIFT, exact for any 16-bit total
  localparam logic [15:0] DIV6_MUL   = 16'd43691;
  localparam int          DIV6_SHIFT = 18;
  localparam logic [9:0]  CUR_SCALE  = 10'd825;
  localparam int          CUR_SHIFT  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_FAULT  = 3'd0,
    CFG_CELL_FAULT  = 3'd1,
    CFG_TOTAL_FAULT = 3'd2,
    CFG_CELL_HIGH   = 3'd3,
    CFG_CELL_LOW    = 3'd4,
    CFG_TOTAL_WARN  = 3'd5,
    CFG_SPREAD_WARN = 3'd6,
    CFG_CURR_WARN   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] temp_fault;
    logic [31:0] cell_fault;
    logic [31:0] total_fault;
    logic [31:0] cell_high;
    logic [31:0] cell_low;
    logic [63:0] total_warn;
    logic [31:0] spread_warn;
    logic [31:0] curr_warn;
  } limits_t;

  typedef struct packed {
    logic [VOLT_W-1:0]   cell_volts_a;
    logic [VOLT_W-1:0]   cell_volts_b;
    logic [VOLT_W-1:0]   cell_volts_c;
    logic [VOLT_W-1:0]   cell_volts_d;
    logic [VOLT_W-1:0]   temperature;
    logic [CODE_W-1:0]   current_code;
    logic [CMD_W-1:0]    contactor_cmd;
    logic [VOLT_W-1:0]   silent_ms;
    logic [FLAGS4_W-1:0] hot_flags;
    logic [FLAGS4_W-1:0] cold_flags;
  } sample_t;

  // contactor[0] main, contactor[1] precharge
  typedef struct packed {
    logic [FAULT_W-1:0] fault;
    logic [WARN_W-1:0]  warn;
    logic [1:0]         contactor;
    logic               fan;
  } mon_state_t;

  typedef struct packed {
    logic [CHARGE_W-1:0] charge_estimate;
    logic [CUR_W-1:0]    current_value;
    logic [VOLT_W-1:0]   total_volts;
    logic [VOLT_W-1:0]   max_volts;
    logic [VOLT_W-1:0]   min_volts;
    logic [FAULT_W-1:0]  fault_bits;
    logic [WARN_W-1:0]   warn_bits;
    logic                main_contactor;
    logic                precharge_contactor;
    logic                link_led;
    logic                fault_relay;
    logic                fan_on;
  } result_t;

endpackage

`default_nettype wire

/* sv/bpam_if.sv */
// ----------------------------------------------------------------------------
// bpam_if - channel interfaces of the battery pack alarm monitor
// Sample, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpam_in_if;
  logic                          valid;
  logic                          ready;
  logic [bpam_pkg::VOLT_W-1:0]   cell_volts_a;
  logic [bpam_pkg::VOLT_W-1:0]   cell_volts_b;
  logic [bpam_pkg::VOLT_W-1:0]   cell_volts_c;
  logic [bpam_pkg::VOLT_W-1:0]   cell_volts_d;
  logic [bpam_pkg::VOLT_W-1:0]   temperature;
  logic [bpam_pkg::CODE_W-1:0]   current_code;
  logic [bpam_pkg::CMD_W-1:0]    contactor_cmd;
  logic [bpam_pkg::VOLT_W-1:0]   silent_ms;
  logic [bpam_pkg::FLAGS4_W-1:0] hot_flags;
  logic [bpam_pkg::FLAGS4_W-1:0] cold_flags;

  modport source (output valid, cell_volts_a, cell_volts_b, cell_volts_c, cell_volts_d,
                  temperature, current_code, contactor_cmd, silent_ms, hot_flags,
                  cold_flags, input ready);
  modport sink (input valid, cell_volts_a, cell_volts_b, cell_volts_c, cell_volts_d,
                temperature, current_code, contactor_cmd, silent_ms, hot_flags,
                cold_flags, output ready);
endinterface

interface bpam_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpam_pkg::CHARGE_W-1:0] charge_estimate;
  logic [bpam_pkg::CUR_W-1:0]    current_value;
  logic [bpam_pkg::VOLT_W-1:0]   total_volts;
  logic [bpam_pkg::VOLT_W-1:0]   max_volts;
  logic [bpam_pkg::VOLT_W-1:0]   min_volts;
  logic [bpam_pkg::FAULT_W-1:0]  fault_bits;
  logic [bpam_pkg::WARN_W-1:0]   warn_bits;
  logic                          main_contactor;
  logic                          precharge_contactor;
  logic                          link_led;
  logic                          fault_relay;
  logic                          fan_on;

  modport source (output valid, charge_estimate, current_value, total_volts, max_volts,
                  min_volts, fault_bits, warn_bits, main_contactor, precharge_contactor,
                  link_led, fault_relay, fan_on, input ready);
  modport sink (input valid, charge_estimate, current_value, total_volts, max_volts,
                min_volts, fault_bits, warn_bits, main_contactor, precharge_contactor,
                link_led, fault_relay, fan_on, output ready);
endinterface

interface bpam_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpam_pkg::CFG_IDX_W-1:0]  index;
  logic [bpam_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/bpam_eval.sv */
// ----------------------------------------------------------------------------
// bpam_eval - one-sample evaluation
// Pack totals, extremes, scaling, hysteresis flags and drive decode.
// ----------------------------------------------------------------------------
`default_nettype none

module bpam_eval (
  input  wire bpam_pkg::sample_t    sample,
  input  wire bpam_pkg::limits_t    limits,
  input  wire bpam_pkg::mon_state_t cur_state,
  output bpam_pkg::mon_state_t      nxt_state,
  output bpam_pkg::result_t         res
);

  function automatic logic hyst_high(input logic flag, input logic [15:0] v,
                                     input logic [15:0] set_th, input logic [15:0] rel_th);
    logic r;
    if (v >= set_th)      r = 1'b1;
    else if (v < rel_th)  r = 1'b0;
    else                  r = flag;
    return r;
  endfunction

  function automatic logic hyst_low(input logic flag, input logic [15:0] v,
                                    input logic [15:0] set_th, input logic [15:0] rel_th);
    logic r;
    if (v <= set_th)      r = 1'b1;
    else if (v > rel_th)  r = 1'b0;
    else                  r = flag;
    return r;
  endfunction

  logic [bpam_pkg::VOLT_W-1:0] v [4];
  logic [bpam_pkg::VOLT_W-1:0] total;
  logic [bpam_pkg::VOLT_W-1:0] max_ab, max_cd, min_ab, min_cd, vmax, vmin, spread;
  logic [31:0]                 div_prod;
  logic [13:0]                 quot6;
  logic [bpam_pkg::CHARGE_W-1:0] charge;
  logic [21:0]                 cur_prod;
  logic [bpam_pkg::CUR_W-1:0]  cur;
  logic                        any_ge, all_lt;
  logic                        f_temp, f_cell;
  logic [1:0]                  cont_nxt;
  logic                        fan_nxt;

  assign v[0] = sample.cell_volts_a;
  assign v[1] = sample.cell_volts_b;
  assign v[2] = sample.cell_volts_c;
  assign v[3] = sample.cell_volts_d;

  assign total = v[0] + v[1] + v[2] + v[3];

  // extremes as a two-level compare tree
  assign max_ab = (v[1] > v[0]) ? v[1] : v[0];
  assign max_cd = (v[3] > v[2]) ? v[3] : v[2];
  assign min_ab = (v[1] < v[0]) ? v[1] : v[0];
  assign min_cd = (v[3] < v[2]) ? v[3] : v[2];
  assign vmax   = (max_cd > max_ab) ? max_cd : max_ab;
  assign vmin   = (min_cd < min_ab) ? min_cd : min_ab;
  assign spread = vmax - vmin;

  // divide by 6 through the reciprocal, then times 5 as shift and add
  assign div_prod = {16'd0, total} * {16'd0, bpam_pkg::DIV6_MUL};
  assign quot6    = div_prod[31:bpam_pkg::DIV6_SHIFT];
  assign charge   = quot6[7:0] + {quot6[5:0], 2'b00};

  assign cur_prod = {10'd0, sample.current_code} * {12'd0, bpam_pkg::CUR_SCALE};
  assign cur      = cur_prod[bpam_pkg::CUR_SHIFT +: bpam_pkg::CUR_W];

  always_comb begin
    any_ge = 1'b0;
    all_lt = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (v[i] >= limits.cell_fault[31:16]) any_ge = 1'b1;
      if (v[i] >= limits.cell_fault[15:0])  all_lt = 1'b0;
    end
  end

  always_comb begin
    if (sample.temperature > limits.temp_fault[31:16])     f_temp = 1'b1;
    else if (sample.temperature < limits.temp_fault[15:0]) f_temp = 1'b0;
    else                                                   f_temp = cur_state.fault[0];

    if (any_ge)      f_cell = 1'b1;
    else if (all_lt) f_cell = 1'b0;
    else             f_cell = cur_state.fault[1];
  end

  // unrecognized commands keep both drives as they are
  always_comb begin
    unique case (sample.contactor_cmd)
      bpam_pkg::CMD_OPEN:      cont_nxt = 2'b00;
      bpam_pkg::CMD_PRECHARGE: cont_nxt = 2'b10;
      bpam_pkg::CMD_MAIN:      cont_nxt = 2'b01;
      default:                 cont_nxt = cur_state.contactor;
    endcase
  end

  always_comb begin
    if (sample.hot_flags != '0)        fan_nxt = 1'b1;
    else if (sample.cold_flags == '1)  fan_nxt = 1'b0;
    else                               fan_nxt = cur_state.fan;
  end

  always_comb begin
    nxt_state.fault[0] = f_temp;
    nxt_state.fault[1] = f_cell;
    nxt_state.fault[2] = hyst_high(cur_state.fault[2], total,
                                   limits.total_fault[31:16], limits.total_fault[15:0]);
    nxt_state.warn[0]  = hyst_high(cur_state.warn[0], vmax,
                                   limits.cell_high[31:16], limits.cell_high[15:0]);
    nxt_state.warn[1]  = hyst_low(cur_state.warn[1], vmin,
                                  limits.cell_low[31:16], limits.cell_low[15:0]);
    nxt_state.warn[2]  = hyst_high(cur_state.warn[2], total,
                                   limits.total_warn[63:48], limits.total_warn[47:32]);
    nxt_state.warn[3]  = hyst_low(cur_state.warn[3], total,
                                  limits.total_warn[31:16], limits.total_warn[15:0]);
    nxt_state.warn[4]  = hyst_high(cur_state.warn[4], spread,
                                   limits.spread_warn[31:16], limits.spread_warn[15:0]);
    nxt_state.warn[5]  = hyst_high(cur_state.warn[5], {2'b00, cur},
                                   limits.curr_warn[31:16], limits.curr_warn[15:0]);
    nxt_state.contactor = cont_nxt;
    nxt_state.fan       = fan_nxt;
  end

  always_comb begin
    res.charge_estimate     = charge;
    res.current_value       = cur;
    res.total_volts         = total;
    res.max_volts           = vmax;
    res.min_volts           = vmin;
    res.fault_bits          = nxt_state.fault;
    res.warn_bits           = nxt_state.warn;
    res.main_contactor      = cont_nxt[0];
    res.precharge_contactor = cont_nxt[1];
    res.link_led            = (sample.silent_ms <= bpam_pkg::LINK_TIMEOUT);
    res.fault_relay         = |nxt_state.fault;
    res.fan_on              = fan_nxt;
  end

endmodule

`default_nettype wire

/* sv/battery_pack_alarm_monitor.sv */
// ----------------------------------------------------------------------------
// battery_pack_alarm_monitor - four-module pack alarm monitor
// Takes one monitoring sample per word and returns one status word per sample.
// ----------------------------------------------------------------------------
// Channels: in_ch carries sample words, out_ch status words, cfg_ch writes the
// eight limit registers (index 0..7, low 32 data bits for 32-bit registers,
// all 64 for the total warning limits). cfg_ch is always ready; writes are
// meant to happen only while no sample is in flight.
// A sample accepted on in_ch is taken into the input register and shows on
// out_ch once the result register is loaded. Throughput: one word per cycle
// while out_ch is not stalled, set by the single evaluation stage between
// the two registers.
// Stall: while out_ch is held, the input register still takes one more word;
// in_ch.ready then drops until the result register frees. Nothing is lost.
// Reset (rst_n low, synchronous): both stages empty, limits zero, fault and
// warning flags clear, contactors open, fan off.
// Flag state advances when a word moves into the result register, so
// results follow the order of accepted samples.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_pack_alarm_monitor (
  input wire           clk,
  input wire           rst_n,
  bpam_in_if.sink      in_ch,
  bpam_out_if.source   out_ch,
  bpam_cfg_if.sink     cfg_ch
);

  bpam_pkg::limits_t    limits_r, limits_nxt;
  bpam_pkg::sample_t    s1_sample_r, s1_sample_nxt;
  logic                 s1_valid_r, s1_valid_nxt;
  bpam_pkg::mon_state_t state_r, state_nxt, eval_state;
  bpam_pkg::result_t    out_res_r, out_res_nxt, eval_res;
  logic                 out_valid_r, out_valid_nxt;

  logic in_acc, out_free, s1_move;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_move  = s1_valid_r && out_free;

  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    limits_nxt = limits_r;
    if (cfg_ch.valid) begin
      unique case (bpam_pkg::cfg_idx_t'(cfg_ch.index))
        bpam_pkg::CFG_TEMP_FAULT:  limits_nxt.temp_fault  = cfg_ch.data[31:0];
        bpam_pkg::CFG_CELL_FAULT:  limits_nxt.cell_fault  = cfg_ch.data[31:0];
        bpam_pkg::CFG_TOTAL_FAULT: limits_nxt.total_fault = cfg_ch.data[31:0];
        bpam_pkg::CFG_CELL_HIGH:   limits_nxt.cell_high   = cfg_ch.data[31:0];
        bpam_pkg::CFG_CELL_LOW:    limits_nxt.cell_low    = cfg_ch.data[31:0];
        bpam_pkg::CFG_TOTAL_WARN:  limits_nxt.total_warn  = cfg_ch.data;
        bpam_pkg::CFG_SPREAD_WARN: limits_nxt.spread_warn = cfg_ch.data[31:0];
        bpam_pkg::CFG_CURR_WARN:   limits_nxt.curr_warn   = cfg_ch.data[31:0];
      endcase
    end
  end

  always_comb begin
    s1_sample_nxt.cell_volts_a  = in_ch.cell_volts_a;
    s1_sample_nxt.cell_volts_b  = in_ch.cell_volts_b;
    s1_sample_nxt.cell_volts_c  = in_ch.cell_volts_c;
    s1_sample_nxt.cell_volts_d  = in_ch.cell_volts_d;
    s1_sample_nxt.temperature   = in_ch.temperature;
    s1_sample_nxt.current_code  = in_ch.current_code;
    s1_sample_nxt.contactor_cmd = in_ch.contactor_cmd;
    s1_sample_nxt.silent_ms     = in_ch.silent_ms;
    s1_sample_nxt.hot_flags     = in_ch.hot_flags;
    s1_sample_nxt.cold_flags    = in_ch.cold_flags;
  end

  bpam_eval u_eval (
    .sample    (s1_sample_r),
    .limits    (limits_r),
    .cur_state (state_r),
    .nxt_state (eval_state),
    .res       (eval_res)
  );

  always_comb begin
    if (in_acc)       s1_valid_nxt = 1'b1;
    else if (s1_move) s1_valid_nxt = 1'b0;
    else              s1_valid_nxt = s1_valid_r;

    if (s1_move)           out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;

    state_nxt   = s1_move ? eval_state : state_r;
    out_res_nxt = s1_move ? eval_res : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      limits_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
      limits_r    <= limits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= s1_sample_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.charge_estimate     = out_res_r.charge_estimate;
  assign out_ch.current_value       = out_res_r.current_value;
  assign out_ch.total_volts         = out_res_r.total_volts;
  assign out_ch.max_volts           = out_res_r.max_volts;
  assign out_ch.min_volts           = out_res_r.min_volts;
  assign out_ch.fault_bits          = out_res_r.fault_bits;
  assign out_ch.warn_bits           = out_res_r.warn_bits;
  assign out_ch.main_contactor      = out_res_r.main_contactor;
  assign out_ch.precharge_contactor = out_res_r.precharge_contactor;
  assign out_ch.link_led            = out_res_r.link_led;
  assign out_ch.fault_relay         = out_res_r.fault_relay;
  assign out_ch.fan_on              = out_res_r.fan_on;

endmodule

`default_nettype wire

/* sv/bpam_checker.sv */
// ----------------------------------------------------------------------------
// bpam_checker - port-level checks for the alarm monitor
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpam_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [bpam_pkg::FAULT_W-1:0]  fault_bits,
  input wire                          fault_relay,
  input wire                          main_contactor,
  input wire                          precharge_contactor
);

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_relay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (fault_relay == (fault_bits != '0)))
    else $error("fault relay disagrees with fault bits");

  // decode never closes both contactors
  a_contactor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(main_contactor && precharge_contactor))
    else $error("main and precharge both closed");

endmodule

bind battery_pack_alarm_monitor bpam_checker u_bpam_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .fault_bits          (out_ch.fault_bits),
  .fault_relay         (out_ch.fault_relay),
  .main_contactor      (out_ch.main_contactor),
  .precharge_contactor (out_ch.precharge_contactor)
);

`default_nettype wire

/* test/bpam_status_checker.sv */
// ----------------------------------------------------------------------------
// bpam_status_checker - status word checker for the pack alarm monitor
// Watches the sample, status and register write channels, keeps its own copy
// of the limits and flag state, predicts one status word per accepted sample
// and compares every accepted status word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpam_status_checker (
  input  wire  clk,
  input  wire  rst_n,
  bpam_in_if   in_mon,
  bpam_out_if  out_mon,
  bpam_cfg_if  cfg_mon,
  output int   mismatches,
  output int   outstanding
);
  import bpam_pkg::*;

  // contactor state: bit0 main, bit1 precharge
  localparam logic [1:0] CONT_OPEN      = 2'b00;
  localparam logic [1:0] CONT_MAIN      = 2'b01;
  localparam logic [1:0] CONT_PRECHARGE = 2'b10;

  limits_t            lim;
  logic [FAULT_W-1:0] fault_st;
  logic [WARN_W-1:0]  warn_st;
  logic [1:0]         cont_st;
  logic               fan_st;
  result_t            status_q[$];

  function automatic logic rise_hyst(input logic cur, input logic [15:0] val,
                                     input logic [31:0] thr);
    if (val >= thr[31:16]) return 1'b1;
    if (val < thr[15:0]) return 1'b0;
    return cur;
  endfunction

  function automatic logic fall_hyst(input logic cur, input logic [15:0] val,
                                     input logic [31:0] thr);
    if (val <= thr[31:16]) return 1'b1;
    if (val > thr[15:0]) return 1'b0;
    return cur;
  endfunction

  // advances the flag state by one sample and returns the status word
  function automatic result_t predict_status(input sample_t s);
    result_t           r;
    logic [15:0]       v [4];
    logic [15:0]       sum, vmax, vmin, spread;
    logic [21:0]       scaled;
    logic [CUR_W-1:0]  cur;
    logic [31:0]       charge;
    logic              any_set, all_clear;
    int                i;
    v[0] = s.cell_volts_a;
    v[1] = s.cell_volts_b;
    v[2] = s.cell_volts_c;
    v[3] = s.cell_volts_d;
    sum = v[0] + v[1] + v[2] + v[3];
    vmax = v[0];
    vmin = v[0];
    any_set = 1'b0;
    all_clear = 1'b1;
    for (i = 0; i < 4; i++) begin
      if (v[i] > vmax) vmax = v[i];
      if (v[i] < vmin) vmin = v[i];
      if (v[i] >= lim.cell_fault[31:16]) any_set = 1'b1;
      if (v[i] >= lim.cell_fault[15:0]) all_clear = 1'b0;
    end
    spread = vmax - vmin;
    scaled = s.current_code * 22'd825;
    cur = scaled[21:8];

    case (s.contactor_cmd)
      CMD_OPEN:      cont_st = CONT_OPEN;
      CMD_PRECHARGE: cont_st = CONT_PRECHARGE;
      CMD_MAIN:      cont_st = CONT_MAIN;
      default:       cont_st = cont_st;
    endcase

    // temperature uses a strict compare on the set side
    if (s.temperature > lim.temp_fault[31:16]) fault_st[0] = 1'b1;
    else if (s.temperature < lim.temp_fault[15:0]) fault_st[0] = 1'b0;
    if (any_set) fault_st[1] = 1'b1;
    else if (all_clear) fault_st[1] = 1'b0;
    fault_st[2] = rise_hyst(fault_st[2], sum, lim.total_fault);

    warn_st[0] = rise_hyst(warn_st[0], vmax, lim.cell_high);
    warn_st[1] = fall_hyst(warn_st[1], vmin, lim.cell_low);
    warn_st[2] = rise_hyst(warn_st[2], sum, lim.total_warn[63:32]);
    warn_st[3] = fall_hyst(warn_st[3], sum, lim.total_warn[31:0]);
    warn_st[4] = rise_hyst(warn_st[4], spread, lim.spread_warn);
    warn_st[5] = rise_hyst(warn_st[5], {2'b00, cur}, lim.curr_warn);

    if (s.hot_flags != 4'h0) fan_st = 1'b1;
    else if (s.cold_flags == 4'hF) fan_st = 1'b0;

    charge = (sum / 16'd6) * 32'd5;
    r.charge_estimate     = charge[7:0];
    r.current_value       = cur;
    r.total_volts         = sum;
    r.max_volts           = vmax;
    r.min_volts           = vmin;
    r.fault_bits          = fault_st;
    r.warn_bits           = warn_st;
    r.main_contactor      = cont_st[0];
    r.precharge_contactor = cont_st[1];
    r.link_led            = (s.silent_ms <= LINK_TIMEOUT);
    r.fault_relay         = |fault_st;
    r.fan_on              = fan_st;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    sample_t s;
    result_t want;
    result_t got;
    if (!rst_n) begin
      lim = '0;
      fault_st = '0;
      warn_st = '0;
      cont_st = CONT_OPEN;
      fan_st = 1'b0;
      status_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_TEMP_FAULT:  lim.temp_fault  = cfg_mon.data[31:0];
          CFG_CELL_FAULT:  lim.cell_fault  = cfg_mon.data[31:0];
          CFG_TOTAL_FAULT: lim.total_fault = cfg_mon.data[31:0];
          CFG_CELL_HIGH:   lim.cell_high   = cfg_mon.data[31:0];
          CFG_CELL_LOW:    lim.cell_low    = cfg_mon.data[31:0];
          CFG_TOTAL_WARN:  lim.total_warn  = cfg_mon.data;
          CFG_SPREAD_WARN: lim.spread_warn = cfg_mon.data[31:0];
          CFG_CURR_WARN:   lim.curr_warn   = cfg_mon.data[31:0];
          default: ;
        endcase
      end
      // pop before push so a word never matches a sample taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.charge_estimate, out_mon.current_value, out_mon.total_volts,
               out_mon.max_volts, out_mon.min_volts, out_mon.fault_bits,
               out_mon.warn_bits, out_mon.main_contactor, out_mon.precharge_contactor,
               out_mon.link_led, out_mon.fault_relay, out_mon.fan_on};
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("status word 0x%0h arrived with no sample pending", got);
        end else begin
          want = status_q.pop_front();
          check_field("charge_estimate", want.charge_estimate, got.charge_estimate);
          check_field("current_value", want.current_value, got.current_value);
          check_field("total_volts", want.total_volts, got.total_volts);
          check_field("max_volts", want.max_volts, got.max_volts);
          check_field("min_volts", want.min_volts, got.min_volts);
          check_field("fault_bits", want.fault_bits, got.fault_bits);
          check_field("warn_bits", want.warn_bits, got.warn_bits);
          check_field("main_contactor", want.main_contactor, got.main_contactor);
          check_field("precharge_contactor", want.precharge_contactor,
                      got.precharge_contactor);
          check_field("link_led", want.link_led, got.link_led);
          check_field("fault_relay", want.fault_relay, got.fault_relay);
          check_field("fan_on", want.fan_on, got.fan_on);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        s = {in_mon.cell_volts_a, in_mon.cell_volts_b, in_mon.cell_volts_c,
             in_mon.cell_volts_d, in_mon.temperature, in_mon.current_code,
             in_mon.contactor_cmd, in_mon.silent_ms, in_mon.hot_flags,
             in_mon.cold_flags};
        status_q.push_back(predict_status(s));
      end
    end
    outstanding <= status_q.size();
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb - battery pack alarm monitor testbench
// Directed boundary samples, then random phases under several limit sets with
// bursty input, a stalling status receiver, one long receiver hold-off and one
// full drain mid-phase. Checking lives in bpam_status_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bpam_pkg::*;

  typedef enum int {LIM_CENTRED, LIM_ZERO, LIM_FULL, LIM_NOISE} limit_kind_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   stall_req = 0;
  int   stall_len = 0;
  int   burst_left = 0;
  int   ctr_v, ctr_t, ctr_c;

  bpam_in_if  in_ch ();
  bpam_out_if out_ch ();
  bpam_cfg_if cfg_ch ();

  battery_pack_alarm_monitor u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bpam_status_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // samples clustered around the phase centers so the hysteresis flags move
  function automatic sample_t shaped_sample();
    sample_t s;
    s.cell_volts_a = 16'(ctr_v + int'($urandom_range(0, 80)) - 40);
    s.cell_volts_b = 16'(ctr_v + int'($urandom_range(0, 80)) - 40);
    s.cell_volts_c = 16'(ctr_v + int'($urandom_range(0, 80)) - 40);
    s.cell_volts_d = 16'(ctr_v + int'($urandom_range(0, 80)) - 40 +
                         (($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 200)) : 0));
    s.temperature  = 16'(ctr_t + int'($urandom_range(0, 100)) - 50);
    s.current_code = 12'(ctr_c + int'($urandom_range(0, 60)) - 30);
    case ($urandom_range(0, 4))
      0:       s.contactor_cmd = CMD_OPEN;
      1:       s.contactor_cmd = CMD_PRECHARGE;
      2:       s.contactor_cmd = CMD_MAIN;
      default: s.contactor_cmd = 8'($urandom);
    endcase
    s.silent_ms  = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(990, 1010))
                                               : 16'($urandom);
    s.hot_flags  = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'h0;
    s.cold_flags = ($urandom_range(0, 2) == 0) ? 4'hF : 4'($urandom);
    return s;
  endfunction

  function automatic sample_t noise_sample();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(sample_t)-1:0];
  endfunction

  function automatic limits_t centred_limits();
    limits_t l;
    int      cur;
    cur = (ctr_c * 825) >>> 8;
    l.temp_fault  = {16'(ctr_t + 20), 16'(ctr_t - 20)};
    l.cell_fault  = {16'(ctr_v + 30), 16'(ctr_v + 10)};
    l.total_fault = {16'(4 * ctr_v + 60), 16'(4 * ctr_v + 20)};
    l.cell_high   = {16'(ctr_v + 20), 16'(ctr_v)};
    l.cell_low    = {16'(ctr_v - 20), 16'(ctr_v)};
    l.total_warn  = {16'(4 * ctr_v + 40), 16'(4 * ctr_v), 16'(4 * ctr_v - 40),
                     16'(4 * ctr_v)};
    l.spread_warn = {16'd60, 16'd30};
    l.curr_warn   = {16'(cur + 20), 16'(cur - 20)};
    return l;
  endfunction

  task automatic send_sample(input sample_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    {in_ch.cell_volts_a, in_ch.cell_volts_b, in_ch.cell_volts_c, in_ch.cell_volts_d,
     in_ch.temperature, in_ch.current_code, in_ch.contactor_cmd, in_ch.silent_ms,
     in_ch.hot_flags, in_ch.cold_flags} <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_fields(input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c, input logic [15:0] d,
                             input logic [15:0] temp, input logic [11:0] code,
                             input logic [7:0] cmd, input logic [15:0] silent,
                             input logic [3:0] hot, input logic [3:0] cold);
    sample_t s;
    s = {a, b, c, d, temp, code, cmd, silent, hot, cold};
    send_sample(s);
  endtask

  // stop offering words and wait until every status word is back
  task automatic wait_drained();
    int n;
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    for (n = 0; n < 5000 && outstanding != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_limits(input limits_t l);
    logic [63:0] words [8];
    int          i;
    words[CFG_TEMP_FAULT]  = {$urandom, l.temp_fault};
    words[CFG_CELL_FAULT]  = {$urandom, l.cell_fault};
    words[CFG_TOTAL_FAULT] = {$urandom, l.total_fault};
    words[CFG_CELL_HIGH]   = {$urandom, l.cell_high};
    words[CFG_CELL_LOW]    = {$urandom, l.cell_low};
    words[CFG_TOTAL_WARN]  = l.total_warn;
    words[CFG_SPREAD_WARN] = {$urandom, l.spread_warn};
    words[CFG_CURR_WARN]   = {$urandom, l.curr_warn};
    for (i = 0; i < 8; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= cfg_idx_t'(i);
      cfg_ch.data  <= words[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // status receiver: ready pattern re-drawn at random from four modes, long hold on request
  initial begin : out_side
    int cyc, mode, seen_req, hold_left;
    cyc = 0;
    mode = 0;
    seen_req = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (stall_req != seen_req) begin
        seen_req = stall_req;
        hold_left = stall_len;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) != 0);
          2:       out_ch.ready <= ($urandom_range(0, 6) != 0);
          default: out_ch.ready <= ((cyc % 8) < 5);
        endcase
      end
    end
  end

  initial begin : stimulus
    limit_kind_t kind;
    int          ph, k;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    {in_ch.cell_volts_a, in_ch.cell_volts_b, in_ch.cell_volts_c, in_ch.cell_volts_d,
     in_ch.temperature, in_ch.current_code, in_ch.contactor_cmd, in_ch.silent_ms,
     in_ch.hot_flags, in_ch.cold_flags} <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_TEMP_FAULT;
    cfg_ch.data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all limits still at reset
    send_fields(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 12'h0, CMD_OPEN, 16'h0, 4'h0, 4'h0);
    send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 8'hFF,
                16'hFFFF, 4'hF, 4'hF);
    send_fields(16'd1, 16'd2, 16'd3, 16'd4, 16'd100, 12'd1, CMD_PRECHARGE, 16'd1000,
                4'h0, 4'hF);
    send_fields(16'd40000, 16'd1, 16'hFFFF, 16'd7, 16'd7, 12'd2048, CMD_MAIN, 16'd1001,
                4'h0, 4'h7);
    send_fields(16'd10, 16'd20, 16'd30, 16'd40, 16'd0, 12'd4094, 8'h07, 16'hFFFF,
                4'h8, 4'h0);

    // thresholds hit exactly, between set and release, and just past release
    ctr_v = 1000;
    ctr_t = 500;
    ctr_c = 2000;
    wait_drained();
    load_limits(centred_limits());
    send_fields(16'd1020, 16'd1020, 16'd1020, 16'd1020, 16'd500, 12'd2000, CMD_OPEN,
                16'd0, 4'h0, 4'h0);
    send_fields(16'd1010, 16'd1010, 16'd1010, 16'd1010, 16'd520, 12'd2010,
                CMD_PRECHARGE, 16'd500, 4'h0, 4'h0);
    send_fields(16'd1030, 16'd1000, 16'd1000, 16'd1000, 16'd521, 12'd2020, CMD_MAIN,
                16'd999, 4'h0, 4'h0);
    send_fields(16'd1010, 16'd990, 16'd990, 16'd990, 16'd480, 12'd1990, 8'h0E,
                16'd1000, 4'h0, 4'h0);
    send_fields(16'd1009, 16'd990, 16'd990, 16'd990, 16'd479, 12'd1980, 8'h01,
                16'd1001, 4'h0, 4'h0);
    send_fields(16'd980, 16'd980, 16'd980, 16'd980, 16'd500, 12'd2000, CMD_OPEN,
                16'd0, 4'h0, 4'h0);
    send_fields(16'd990, 16'd990, 16'd990, 16'd990, 16'd500, 12'd2000, 8'h10,
                16'd0, 4'h0, 4'h0);
    send_fields(16'd1001, 16'd1001, 16'd1001, 16'd1001, 16'd500, 12'd2000, 8'hF0,
                16'd0, 4'h0, 4'h0);
    send_fields(16'd1100, 16'd1000, 16'd1000, 16'd1000, 16'd500, 12'd2000, CMD_MAIN,
                16'd0, 4'h0, 4'h0);
    send_fields(16'd1000, 16'd1045, 16'd1000, 16'd1000, 16'd500, 12'd2000, 8'h80,
                16'd0, 4'h0, 4'h0);
    send_fields(16'd1000, 16'd1000, 16'd1020, 16'd1000, 16'd500, 12'd2000, 8'hFF,
                16'd0, 4'h0, 4'h0);
    send_fields(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd500, 12'd0, CMD_OPEN,
                16'd0, 4'h0, 4'h0);
    send_fields(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd500, 12'hFFF, CMD_OPEN,
                16'd0, 4'h0, 4'h0);
    send_fields(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd500, 12'd2000, CMD_OPEN,
                16'd0, 4'h0, 4'hF);
    send_fields(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd500, 12'd2000, CMD_OPEN,
                16'd0, 4'h1, 4'hE);
    send_fields(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd500, 12'd2000, CMD_OPEN,
                16'd0, 4'h2, 4'hF);
    send_fields(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd500, 12'd2000, CMD_OPEN,
                16'd1000, 4'h0, 4'hE);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin kind = LIM_CENTRED; ctr_v = $urandom_range(100, 3000);     end
        1:       begin kind = LIM_ZERO;    ctr_v = 30;                            end
        2:       begin kind = LIM_CENTRED; ctr_v = $urandom_range(10000, 16300);  end
        3:       begin kind = LIM_FULL;    ctr_v = 65500;                         end
        4:       begin kind = LIM_NOISE;   ctr_v = $urandom_range(0, 65535);      end
        default: begin kind = LIM_CENTRED; ctr_v = 16380;                         end
      endcase
      ctr_t = $urandom_range(50, 65000);
      ctr_c = $urandom_range(30, 4065);
      wait_drained();
      case (kind)
        LIM_ZERO:  load_limits('0);
        LIM_FULL:  load_limits('1);
        LIM_NOISE: load_limits({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom});
        default:   load_limits(centred_limits());
      endcase
      for (k = 0; k < 175; k++) begin
        // receiver holds off while words keep coming, so the input backs up
        if (ph == 2 && k == 60) begin
          stall_len = 80;
          stall_req++;
        end
        if (ph == 4 && k == 90) wait_drained();
        if ($urandom_range(0, 4) == 0) send_sample(noise_sample());
        else send_sample(shaped_sample());
      end
    end

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
